@@ src/penc_pkg.sv @@
// penc_pkg: shared types, constants and helpers of the percent encoder
// used by every module of the block; depends on nothing
`default_nettype none

package penc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_ADDR_W  = 6;
  localparam int unsigned NUM_MASKS   = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [BYTE_W-1:0] HI_NIBBLE    = 8'hf0;

  // register indexes, paddr[5:3]
  typedef enum logic [2:0] {
    REG_KEEP_0  = 3'd0,
    REG_KEEP_1  = 3'd1,
    REG_KEEP_2  = 3'd2,
    REG_KEEP_3  = 3'd3,
    REG_FORCE_0 = 3'd4,
    REG_FORCE_1 = 3'd5,
    REG_FORCE_2 = 3'd6,
    REG_FORCE_3 = 3'd7
  } reg_idx_t;

  // position inside an escape sequence
  typedef enum logic [1:0] {
    PH_PCT = 2'd0,
    PH_HI  = 2'd1,
    PH_LO  = 2'd2
  } phase_t;

  // classified item held in the queue
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              final_char;
    logic              pass;
  } entry_t;

  function automatic logic is_unreserved(input logic [BYTE_W-1:0] c);
    logic hit;
    case (c) inside
      [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
      8'h2D, 8'h2E, 8'h5F, 8'h7E: hit = 1'b1;
      default:                    hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] n);
    logic [BYTE_W-1:0] d;
    case (n) inside
      [4'h0:4'h9]: d = 8'h30 + {4'h0, n};
      default:     d = 8'h37 + {4'h0, n};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/penc_front.sv @@
// penc_front: accepts input items and decides pass-through or escape
// depends on penc_pkg
`default_nettype none

module penc_front (
  input  wire logic [penc_pkg::BYTE_W-1:0]       text_byte,
  input  wire logic                              final_char,
  input  wire logic [4*penc_pkg::CFG_DATA_W-1:0] keep_bits,
  input  wire logic [4*penc_pkg::CFG_DATA_W-1:0] force_bits,
  output penc_pkg::entry_t                       entry
);

  logic keep_hit;
  logic force_hit;
  logic not_nul;

  // byte zero never matches a mask
  assign not_nul   = (text_byte != penc_pkg::CHAR_NUL);
  assign keep_hit  = not_nul && keep_bits[text_byte];
  assign force_hit = not_nul && force_bits[text_byte];

  always_comb begin
    entry.text_byte  = text_byte;
    entry.final_char = final_char;
    entry.pass       = (penc_pkg::is_unreserved(text_byte) || keep_hit) && !force_hit;
  end

endmodule

`default_nettype wire

@@ src/penc_queue.sv @@
// penc_queue: short fifo of classified items between front and back
// depends on penc_pkg
`default_nettype none

module penc_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire penc_pkg::entry_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop,
  output penc_pkg::entry_t      pop_data
);

  penc_pkg::entry_t                 mem_r [penc_pkg::QUEUE_DEPTH];
  logic [penc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [penc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [penc_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (count_r != penc_pkg::QCNT_W'(penc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ src/penc_back.sv @@
// penc_back: expands queued items into output bytes behind an output register
// depends on penc_pkg
`default_nettype none

module penc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire penc_pkg::entry_t            q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [penc_pkg::BYTE_W-1:0]      out_byte,
  output logic                             run_end,
  output logic                             text_end
);

  penc_pkg::phase_t              phase_r, phase_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [penc_pkg::BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                          run_end_r, run_end_nxt;
  logic                          text_end_r, text_end_nxt;
  logic                          load;
  logic                          take;
  logic [3:0]                    hi_bits;

  assign load    = !out_valid_r || out_ready;
  assign take    = load && q_valid;
  assign hi_bits = 4'((q_data.text_byte & penc_pkg::HI_NIBBLE) >> 4);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take && !q_data.pass) begin
      case (phase_r)
        penc_pkg::PH_PCT: phase_nxt = penc_pkg::PH_HI;
        penc_pkg::PH_HI:  phase_nxt = penc_pkg::PH_LO;
        penc_pkg::PH_LO:  phase_nxt = penc_pkg::PH_PCT;
        default:          phase_nxt = penc_pkg::PH_PCT;
      endcase
    end
  end

  // output register load and queue pop
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    run_end_nxt   = run_end_r;
    text_end_nxt  = text_end_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = q_valid;
    end
    if (take) begin
      if (q_data.pass) begin
        out_byte_nxt = q_data.text_byte;
        run_end_nxt  = 1'b1;
        text_end_nxt = q_data.final_char;
        q_pop        = 1'b1;
      end else begin
        case (phase_r)
          penc_pkg::PH_PCT: begin
            out_byte_nxt = penc_pkg::CHAR_PERCENT;
            run_end_nxt  = 1'b0;
            text_end_nxt = 1'b0;
          end
          penc_pkg::PH_HI: begin
            out_byte_nxt = penc_pkg::hex_digit(hi_bits);
            run_end_nxt  = 1'b0;
            text_end_nxt = 1'b0;
          end
          penc_pkg::PH_LO: begin
            out_byte_nxt = penc_pkg::hex_digit(q_data.text_byte[3:0]);
            run_end_nxt  = 1'b1;
            text_end_nxt = q_data.final_char;
            q_pop        = 1'b1;
          end
          default: begin
            out_byte_nxt = penc_pkg::CHAR_PERCENT;
            run_end_nxt  = 1'b0;
            text_end_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= penc_pkg::PH_PCT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    run_end_r  <= run_end_nxt;
    text_end_r <= text_end_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign run_end   = run_end_r;
  assign text_end  = text_end_r;

endmodule

`default_nettype wire

@@ src/percent_encoder_latin1.sv @@
// percent_encoder_latin1: url percent encoder for latin-1 bytes, top level
// depends on penc_pkg, penc_front, penc_queue, penc_back
// an accepted item is written into the queue, then into the output register
// a passed byte gives one output byte and an escaped byte three, written one byte
//   a cycle into the back end output register while the output is not stalled
// reset: synchronous active-low rst_n clears queue, phase, output valid and masks
`default_nettype none

module percent_encoder_latin1 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // final_char
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // run_end
  output logic [0:0]       out_tuser,  // [0] text_end
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  // mask registers, four 64-bit words each
  logic [penc_pkg::CFG_DATA_W-1:0] keep_r  [penc_pkg::NUM_MASKS];
  logic [penc_pkg::CFG_DATA_W-1:0] force_r [penc_pkg::NUM_MASKS];
  logic                            cfg_wr;
  penc_pkg::reg_idx_t              cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = penc_pkg::reg_idx_t'(cfg_paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < penc_pkg::NUM_MASKS; i++) begin
        keep_r[i]  <= '0;
        force_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      // upper index bit picks the mask, low two bits the word
      if (cfg_idx[2]) begin
        force_r[cfg_idx[1:0]] <= cfg_pwdata;
      end else begin
        keep_r[cfg_idx[1:0]] <= cfg_pwdata;
      end
    end
  end

  // read back
  always_comb begin
    if (cfg_idx[2]) begin
      cfg_prdata = force_r[cfg_idx[1:0]];
    end else begin
      cfg_prdata = keep_r[cfg_idx[1:0]];
    end
  end

  // flat 256-bit views, bit b for byte b
  logic [4*penc_pkg::CFG_DATA_W-1:0] keep_bits;
  logic [4*penc_pkg::CFG_DATA_W-1:0] force_bits;
  assign keep_bits  = {keep_r[3], keep_r[2], keep_r[1], keep_r[0]};
  assign force_bits = {force_r[3], force_r[2], force_r[1], force_r[0]};

  // front: classify the incoming item
  penc_pkg::entry_t front_entry;

  penc_front u_front (
    .text_byte  (in_tdata),
    .final_char (in_tlast),
    .keep_bits  (keep_bits),
    .force_bits (force_bits),
    .entry      (front_entry)
  );

  // queue decouples input acceptance from byte expansion
  logic             q_valid;
  logic             q_pop;
  penc_pkg::entry_t q_data;

  penc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // back: one output byte per cycle unless the output stalls, three bytes per escape
  logic text_end;

  penc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .run_end   (out_tlast),
    .text_end  (text_end)
  );

  assign out_tuser = text_end;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for percent_encoder_latin1, byte stream in, encoded stream out
// masks are loaded over the apb port; needs penc_pkg and the encoder rtl

module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int          N_EDGE        = 21;

  // boundaries of the unreserved ranges, the marks, and a few neighbors
  localparam logic [7:0] EDGE_CHARS [N_EDGE] = '{
    8'h00, 8'hFF, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h2D, 8'h2E, 8'h5F,
    8'h7E, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h25, 8'h7F, 8'h80
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       text_end;
  } enc_byte_t;

  // dut inputs, all known from time zero
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [7:0]  in_tdata    = 8'h00;
  logic        in_tlast    = 1'b0;
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [5:0]  cfg_paddr   = 6'd0;
  logic [63:0] cfg_pwdata  = 64'd0;

  // dut outputs
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;   // [7:0] out_byte
  logic        out_tlast;   // run_end
  logic [0:0]  out_tuser;   // [0] text_end
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // bench-side copy of the masks, bit b stands for byte b
  logic [255:0] keep_bits  = '0;
  logic [255:0] force_bits = '0;

  text_item_t text_q[$];      // bytes waiting to be offered
  enc_byte_t  encoded_q[$];   // encoded bytes the block still owes us

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_cnt      = 0;
  int unsigned n_accepted    = 0;
  int unsigned n_passed      = 0;
  int unsigned n_escaped     = 0;
  int unsigned n_checked     = 0;
  int unsigned n_settings    = 0;
  int unsigned cycle_cnt     = 0;

  text_item_t next_item;
  enc_byte_t  got_byte;
  enc_byte_t  want_byte;
  int         k;

  percent_encoder_latin1 u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // encoder prediction
  // ---------------------------------------------------------------------

  // letters, digits and the four marks that never need escaping
  function automatic logic url_safe(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) ||
           c == 8'h2D || c == 8'h2E || c == 8'h5F || c == 8'h7E;
  endfunction

  // uppercase hex digit for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
  endfunction

  // queues the one or three bytes that an accepted text byte turns into
  function automatic void predict_encoding(input logic [7:0] c, input logic fin);
    logic      kept;
    logic      forced;
    enc_byte_t e;
    // the nul byte ignores both masks, so it always ends up escaped
    kept   = (c != penc_pkg::CHAR_NUL) && keep_bits[c];
    forced = (c != penc_pkg::CHAR_NUL) && force_bits[c];
    if ((url_safe(c) || kept) && !forced) begin
      e = {c, 1'b1, fin};
      encoded_q.push_back(e);
      n_passed++;
    end else begin
      e = {penc_pkg::CHAR_PERCENT, 1'b0, 1'b0};
      encoded_q.push_back(e);
      e = {hex_char(c[7:4]), 1'b0, 1'b0};
      encoded_q.push_back(e);
      // run_end and the end-of-text flag ride on the low digit only
      e = {hex_char(c[3:0]), 1'b1, fin};
      encoded_q.push_back(e);
      n_escaped++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  function automatic void queue_text(input logic [7:0] c, input logic fin);
    text_item_t t;
    t = {c, fin};
    text_q.push_back(t);
  endfunction

  // mix of arbitrary bytes, unreserved ones, controls and the upper half
  function automatic text_item_t random_text_item();
    text_item_t t;
    case ($urandom_range(9))
      4:       t.ch = 8'($urandom_range(8'h5A, 8'h41));
      5:       t.ch = 8'($urandom_range(8'h7A, 8'h61));
      6:       t.ch = 8'($urandom_range(8'h39, 8'h30));
      7: begin
        case ($urandom_range(3))
          0:       t.ch = 8'h2D;
          1:       t.ch = 8'h2E;
          2:       t.ch = 8'h5F;
          default: t.ch = 8'h7E;
        endcase
      end
      8:       t.ch = 8'($urandom_range(8'h1F, 8'h00));
      9:       t.ch = 8'($urandom_range(8'hFF, 8'h80));
      default: t.ch = 8'($urandom_range(8'hFF, 8'h00));
    endcase
    t.fin = ($urandom_range(7) == 0);
    return t;
  endfunction

  function automatic void queue_random(input int unsigned n);
    repeat (n) text_q.push_back(random_text_item());
  endfunction

  // each extra and-pass thins the mask out by half
  function automatic logic [255:0] random_mask(input int unsigned thin);
    logic [255:0] m;
    for (int i = 0; i < 8; i++) m[i*32 +: 32] = $urandom;
    repeat (thin) begin
      for (int i = 0; i < 8; i++) m[i*32 +: 32] &= $urandom;
    end
    return m;
  endfunction

  // sampled on the falling edge, away from the clocked processes
  task automatic wait_drained();
    do @(negedge clk);
    while (text_q.size() != 0 || in_tvalid || encoded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // writes all eight mask registers, only called while the block is idle
  task automatic load_masks(input logic [255:0] keep, input logic [255:0] frc);
    penc_pkg::reg_idx_t idx;
    logic [63:0]        val;
    idx = idx.first();
    repeat (penc_pkg::NUM_MASKS * 2) begin
      if (idx < penc_pkg::REG_FORCE_0) begin
        val = keep[(int'(idx) % penc_pkg::NUM_MASKS) * 64 +: 64];
      end else begin
        val = frc[(int'(idx) % penc_pkg::NUM_MASKS) * 64 +: 64];
      end
      // setup cycle
      @(posedge clk);
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {idx, 3'b000};
      cfg_pwdata  <= val;
      // access cycle, register takes the data once pready is seen
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;
      idx = idx.next();
    end
    keep_bits  = keep;
    force_bits = frc;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------
  // driver: offers queued text bytes, holds each one until accepted
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_encoding(in_tdata, in_tlast);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = text_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.ch;
          in_tlast  <= next_item.fin;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: random back-pressure, checks every accepted output byte
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_byte = {out_tdata, out_tlast, out_tuser[0]};
        n_checked++;
        if (encoded_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("unexpected output item: byte %h run_end %b text_end %b",
                     got_byte.ch, got_byte.run_end, got_byte.text_end);
          end
        end else begin
          want_byte = encoded_q.pop_front();
          if (got_byte.ch !== want_byte.ch || got_byte.run_end !== want_byte.run_end ||
              got_byte.text_end !== want_byte.text_end) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("mismatch: expected byte %h run_end %b text_end %b, got %h %b %b",
                       want_byte.ch, want_byte.run_end, want_byte.text_end,
                       got_byte.ch, got_byte.run_end, got_byte.text_end);
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycle_cnt, encoded_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // slow sender, slower receiver
    send_idle_pct = 38;
    recv_idle_pct = 78;

    // masks at reset value: range edges, the marks and their neighbors
    for (k = 0; k < N_EDGE; k++) begin
      queue_text(EDGE_CHARS[k], (k == 1) || (k == N_EDGE - 1));
    end
    wait_drained();

    // keep everything: all pass except nul, which ignores the masks
    load_masks('1, '0);
    queue_text(8'h00, 1'b0);
    queue_text(8'h20, 1'b0);
    queue_text(8'hFF, 1'b1);
    wait_drained();

    // force everything: even unreserved bytes get escaped
    load_masks('1, '1);
    queue_text(8'h41, 1'b0);
    queue_text(8'h7E, 1'b1);
    wait_drained();

    // back to all-clear masks for the first random stretch
    load_masks('0, '0);
    queue_random(160);
    wait_drained();

    // receiver now the faster side, dense random masks
    send_idle_pct = 78;
    recv_idle_pct = 38;
    load_masks(random_mask(0), random_mask(1));
    queue_random(160);
    wait_drained();

    // full rate both ways, sparse masks, with one full drain in the middle
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_masks(random_mask(1), random_mask(3));
    queue_random(80);
    wait_drained();
    queue_random(80);
    wait_drained();

    fail_cnt += encoded_q.size();
    $display("%0d text items in, %0d sent through as is and %0d escaped, %0d output items checked",
             n_accepted, n_passed, n_escaped, n_checked);
    $display("%0d mask loads incl. all-keep and all-force, under three pacing mixes",
             n_settings);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
